/* sv/encoder_speed_pi_controller_defines.svh */
// Assertion macros shared by the encoder speed controller modules.
`ifndef ENCODER_SPEED_PI_CONTROLLER_DEFINES_SVH
`define ENCODER_SPEED_PI_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ESP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esp assertion failed");
// Next-cycle implication, checked out of reset.
`define ESP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esp assertion failed");
`else
`define ESP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ESP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/esp_pkg.sv */
`timescale 1ns / 1ps

package esp_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegWindowTicks    = 3'd0;
  localparam logic [2:0] RegSpeedScale     = 3'd1;
  localparam logic [2:0] RegSpeedCommand   = 3'd2;
  localparam logic [2:0] RegPropGain       = 3'd3;
  localparam logic [2:0] RegIntegralGainDt = 3'd4;
  localparam logic [2:0] RegPwmLimit       = 3'd5;

  // P and I clamp, 255.0 in Q16.16
  localparam int unsigned ClampQ16 = 255 * 65536;

  typedef struct packed {
    logic [7:0]         window_ticks;
    logic [15:0]        speed_scale;
    logic signed [31:0] speed_command;
    logic [15:0]        prop_gain;
    logic [23:0]        integral_gain_dt;
    logic [7:0]         pwm_limit;
  } esp_cfg_t;

  localparam esp_cfg_t CfgReset = '{
    window_ticks:     8'd100,
    speed_scale:      16'd766,
    speed_command:    32'sd32768,
    prop_gain:        16'd51200,
    integral_gain_dt: 24'd0,
    pwm_limit:        8'd200
  };

endpackage

/* sv/esp_window.sv */
`timescale 1ns / 1ps
`include "encoder_speed_pi_controller_defines.svh"

module esp_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                encoder_level,
  input  esp_pkg::esp_cfg_t   cfg,
  output logic                spd_valid,
  output logic [23:0]         speed,
  input  logic                spd_take
);

  logic       previous_level;
  logic [7:0] tick_count;
  logic [7:0] edge_count;
  logic [7:0] tick_base;
  logic [7:0] edge_base;
  logic [7:0] tick_count_next;
  logic [7:0] edge_count_next;
  logic       window_end;
  logic       slot_free;
  logic       accept;

  // Take a request whenever the speed slot is empty or draining
  assign slot_free  = !spd_valid || spd_take;
  assign in_stall   = !slot_free;
  assign accept     = in_valid && slot_free;
  assign window_end = tick_count >= cfg.window_ticks;

  // Restart counts at a window end; this tick's edge opens the new window
  always_comb begin
    tick_base       = window_end ? 8'd0 : tick_count;
    edge_base       = window_end ? 8'd0 : edge_count;
    tick_count_next = (tick_base != 8'hFF) ? tick_base + 8'd1 : tick_base;
    edge_count_next = edge_base;
    if (encoder_level != previous_level && edge_base != 8'hFF) begin
      edge_count_next = edge_base + 8'd1;
    end
  end

  // Advance counters and the speed slot
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      tick_count     <= 8'd0;
      edge_count     <= 8'd0;
      spd_valid      <= 1'b0;
    end else begin
      if (spd_take) begin
        spd_valid <= 1'b0;
      end
      if (accept) begin
        previous_level <= encoder_level;
        tick_count     <= tick_count_next;
        edge_count     <= edge_count_next;
        if (window_end) begin
          spd_valid <= 1'b1;
        end
      end
    end
  end

  // Speed over the finished window
  always_ff @(posedge clk) begin
    if (accept && window_end) begin
      speed <= 24'(edge_count) * 24'(cfg.speed_scale);
    end
  end

  `ESP_ASSERT_IMP(a_edge_le_tick, clk, rst, 1'b1, edge_count <= tick_count)
  `ESP_ASSERT_NXT(a_window_load, clk, rst, accept && window_end, spd_valid)
  `ESP_ASSERT_NXT(a_speed_hold, clk, rst, spd_valid && !spd_take, $stable(speed))

endmodule

/* sv/esp_pi.sv */
`timescale 1ns / 1ps
`include "encoder_speed_pi_controller_defines.svh"

module esp_pi (
  input  logic                clk,
  input  logic                rst,
  input  esp_pkg::esp_cfg_t   cfg,
  input  logic                spd_valid,
  input  logic [23:0]         speed,
  output logic                spd_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         measured_speed,
  output logic [7:0]          drive_pwm
);

  localparam logic signed [42:0] PHi = 43'(esp_pkg::ClampQ16);
  localparam logic signed [42:0] PLo = -PHi;
  localparam logic signed [47:0] IHi = 48'(esp_pkg::ClampQ16);
  localparam logic signed [47:0] ILo = -IHi;

  // Product stage
  logic               a_valid;
  logic [23:0]        a_speed;
  logic signed [50:0] prod_p;
  logic signed [58:0] prod_i;
  logic signed [33:0] err;
  logic signed [50:0] prod_p_next;
  logic signed [58:0] prod_i_next;

  // Integrate and output stage
  logic signed [47:0] integral_sum;
  logic signed [47:0] integral_sum_next;
  logic signed [42:0] p_sh;
  logic signed [42:0] inc;
  logic signed [48:0] isum_wide;
  logic signed [25:0] p_c;
  logic signed [25:0] i_c;
  logic signed [25:0] pi_sum;
  logic [8:0]         pwm_whole;
  logic [7:0]         pwm;
  logic               out_free;
  logic               adv_out;
  logic               a_free;

  // Handshake between stages
  assign out_free = !out_valid || !out_stall;
  assign adv_out  = a_valid && out_free;
  assign a_free   = !a_valid || adv_out;
  assign spd_take = spd_valid && a_free;

  // Error and gain products
  always_comb begin
    err         = {{2{cfg.speed_command[31]}}, cfg.speed_command} - $signed({10'b0, speed});
    prod_p_next = err * $signed({1'b0, cfg.prop_gain});
    prod_i_next = err * $signed({1'b0, cfg.integral_gain_dt});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (spd_take) begin
      a_valid <= 1'b1;
    end else if (adv_out) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spd_take) begin
      a_speed <= speed;
      prod_p  <= prod_p_next;
      prod_i  <= prod_i_next;
    end
  end

  // Clamp P, saturate the integral, clamp I, form the duty
  always_comb begin
    p_sh = prod_p[50:8];
    inc  = prod_i[58:16];

    if (p_sh > PHi) begin
      p_c = 26'(PHi);
    end else if (p_sh < PLo) begin
      p_c = 26'(PLo);
    end else begin
      p_c = 26'(p_sh);
    end

    isum_wide = {integral_sum[47], integral_sum} + 49'(inc);
    if (isum_wide[48] != isum_wide[47]) begin
      integral_sum_next = isum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      integral_sum_next = isum_wide[47:0];
    end

    if (integral_sum_next > IHi) begin
      i_c = 26'(IHi);
    end else if (integral_sum_next < ILo) begin
      i_c = 26'(ILo);
    end else begin
      i_c = 26'(integral_sum_next);
    end

    pi_sum    = p_c + i_c;
    pwm_whole = pi_sum[24:16];
    if (pi_sum <= 26'sd0) begin
      pwm = 8'd0;
    end else if (pwm_whole >= {1'b0, cfg.pwm_limit}) begin
      pwm = cfg.pwm_limit;
    end else begin
      pwm = pwm_whole[7:0];
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      integral_sum <= '0;
    end else if (adv_out) begin
      out_valid    <= 1'b1;
      integral_sum <= integral_sum_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      measured_speed <= a_speed;
      drive_pwm      <= pwm;
    end
  end

  `ESP_ASSERT_IMP(a_pwm_limit, clk, rst, out_valid, drive_pwm <= cfg.pwm_limit)
  `ESP_ASSERT_NXT(a_integ_hold, clk, rst, !adv_out, $stable(integral_sum))
  `ESP_ASSERT_NXT(a_stage_hold, clk, rst, a_valid && !adv_out, a_valid)

endmodule

/* sv/encoder_speed_pi_controller.sv */
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// in        in_valid / in_stall     encoder_level
// out       out_valid / out_stall   measured_speed, drive_pwm
// cfg       cfg_write               cfg_index, cfg_data
//
// One sample tick is taken per cycle while in_stall is low; a closing tick's
// speed, gain products and integrate/clamp result are registered in turn.
// The integral feedback closes within the last stage, so windows may end on
// every tick. Reset is synchronous and restores the register defaults and
// clears counts and the integral. A stalled output holds; once the three
// result stages fill, in_stall rises until the consumer drains a result.

module encoder_speed_pi_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        encoder_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] measured_speed,
  output logic [7:0]  drive_pwm,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  esp_pkg::esp_cfg_t cfg;
  logic              spd_valid;
  logic [23:0]       speed;
  logic              spd_take;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= esp_pkg::CfgReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        esp_pkg::RegWindowTicks:    cfg.window_ticks     <= cfg_data[7:0];
        esp_pkg::RegSpeedScale:     cfg.speed_scale      <= cfg_data[15:0];
        esp_pkg::RegSpeedCommand:   cfg.speed_command    <= cfg_data;
        esp_pkg::RegPropGain:       cfg.prop_gain        <= cfg_data[15:0];
        esp_pkg::RegIntegralGainDt: cfg.integral_gain_dt <= cfg_data[23:0];
        esp_pkg::RegPwmLimit:       cfg.pwm_limit        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  esp_window u_window (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .encoder_level (encoder_level),
    .cfg           (cfg),
    .spd_valid     (spd_valid),
    .speed         (speed),
    .spd_take      (spd_take)
  );

  esp_pi u_pi (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .spd_valid      (spd_valid),
    .speed          (speed),
    .spd_take       (spd_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .measured_speed (measured_speed),
    .drive_pwm      (drive_pwm)
  );

endmodule
